FILE: rtl/sha1h_pkg.sv
// shared types, constants and helpers for the sha-1 byte stream hash unit
package sha1h_pkg;

    typedef logic [31:0] t_word;
    typedef logic [4:0][31:0] t_hash;

    localparam t_hash HASH_INIT = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                   32'hefcdab89, 32'h67452301};

    localparam t_word K_ROUND0 = 32'h5a827999;
    localparam t_word K_ROUND1 = 32'h6ed9eba1;
    localparam t_word K_ROUND2 = 32'h8f1bbcdc;
    localparam t_word K_ROUND3 = 32'hca62c1d6;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam int unsigned ROUNDS = 80;

    // block buffer write request from the sequencer
    typedef struct packed {
        logic        byte_wr;
        logic        pad_wr;
        logic        zero_all;
        logic        put_len;
        logic [5:0]  pos;
        logic [7:0]  data;
        logic [63:0] bit_len;
    } t_buf_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_stat;

    // keep bytes above the lane, place the byte, clear the bytes below
    function automatic t_word merge_byte(input t_word old, input logic [1:0] lane,
                                         input logic [7:0] b);
        t_word res;
        unique case (lane)
            2'd0: res = {b, 24'h000000};
            2'd1: res = {old[31:24], b, 16'h0000};
            2'd2: res = {old[31:16], b, 8'h00};
            2'd3: res = {old[31:8], b};
            default: res = old;
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/sha1h_engine.sv
// sha-1 round engine: block buffer doubling as message schedule, one round per cycle
module sha1h_engine
    import sha1h_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_init,
    input  t_buf_cmd  i_cmd,
    output t_eng_stat o_stat,
    output t_hash     o_hash
);

    localparam int unsigned RND_W = $clog2(ROUNDS);

    t_hash            r_h;
    t_word            r_a, r_b, r_c, r_d, r_e;
    t_word            r_w [16];
    t_word            n_w [16];
    logic [RND_W-1:0] r_rnd;
    logic             r_run;
    logic             r_add;

    t_word f_val;
    t_word k_val;
    t_word t_val;
    t_word w_new;
    logic [3:0] wi;
    logic [1:0] lane;

    assign wi   = i_cmd.pos[5:2];
    assign lane = i_cmd.pos[1:0];

    always_comb begin
        if (r_rnd < RND_W'(20)) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = K_ROUND0;
        end else if (r_rnd < RND_W'(40)) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_ROUND1;
        end else if (r_rnd < RND_W'(60)) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = K_ROUND2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_ROUND3;
        end
        t_val = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + r_w[0];
    end

    assign w_new = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];

    always_comb begin
        for (int j = 0; j < 16; j++) begin
            n_w[j] = r_w[j];
            if (r_run) begin
                n_w[j] = (j == 15) ? {w_new[30:0], w_new[31]} : r_w[(j + 1) % 16];
            end else begin
                if (i_cmd.byte_wr && wi == 4'(j)) begin
                    n_w[j] = merge_byte(r_w[j], lane, i_cmd.data);
                end
                if (i_cmd.pad_wr) begin
                    if (i_cmd.zero_all || wi < 4'(j)) begin
                        n_w[j] = '0;
                    end else if (wi == 4'(j)) begin
                        n_w[j] = merge_byte(r_w[j], lane, PAD_MARK);
                    end
                    if (i_cmd.put_len && j == 14) begin
                        n_w[j] = i_cmd.bit_len[63:32];
                    end
                    if (i_cmd.put_len && j == 15) begin
                        n_w[j] = i_cmd.bit_len[31:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 16; j++) begin
            r_w[j] <= n_w[j];
        end
        if (i_start) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (r_run) begin
            r_a <= t_val;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h   <= HASH_INIT;
            r_run <= 1'b0;
            r_add <= 1'b0;
            r_rnd <= '0;
        end else begin
            if (i_init) begin
                r_h <= HASH_INIT;
            end else if (r_add) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
            r_add <= r_run & ~i_start & (r_rnd == RND_W'(ROUNDS - 1));
            if (i_start) begin
                r_run <= 1'b1;
                r_rnd <= '0;
            end else if (r_run) begin
                r_rnd <= r_rnd + 1'b1;
                if (r_rnd == RND_W'(ROUNDS - 1)) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    assign o_stat.busy = r_run | r_add;
    assign o_stat.done = r_add;
    assign o_hash      = r_h;

endmodule

FILE: rtl/sha1_byte_stream_hash_unit.sv
// sha-1 byte stream hash unit: byte sequencer, padding control and digest output
//
// input channel: one message byte per request (i_data_byte), with i_is_last on the
// final request; i_carries_no_byte marks a request without a byte (empty message or
// a bare end mark). requests move on i_in_valid / o_in_ready.
// output channel: one 160-bit digest per message on o_out_valid / i_out_ready,
// split into o_digest_high, o_digest_middle and o_digest_low (big-endian).
// a byte that does not complete a 64-byte block is written into the block buffer
// when it is accepted; unless it is the last, the unit then stays ready.
// a byte that completes a block starts a compression: the working words load on
// the accepting edge, then 80 rounds run at one per cycle and an add step folds
// them into the chaining words; the unit is not ready until that add is done, so
// the round engine sets the rate on long messages. the last request adds one or
// two padded compressions (two when 56 or more bytes sit in the final block),
// then the digest is registered; when the last byte fills a block, the padded
// block follows the compression of that full block.
// a digest waiting in the output register does not block new bytes; only the next
// digest waits for i_out_ready.
// reset brings the chaining words to the sha-1 initial values and clears the byte
// count; after each digest the unit returns to that state by itself.
module sha1_byte_stream_hash_unit
    import sha1h_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_last,
    input  logic        i_carries_no_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_digest_high,
    output logic [63:0] o_digest_middle,
    output logic [31:0] o_digest_low
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_COMP = 2'd1;
    localparam logic [1:0] S_PAD  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [60:0] r_count, n_count;
    logic        r_pend_pad, n_pend_pad;
    logic        r_second, n_second;
    logic        r_final, n_final;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_dig_high, r_dig_middle;
    logic [31:0] r_dig_low;

    t_buf_cmd  s_cmd;
    t_eng_stat s_eng;
    t_hash     s_hash;
    logic      s_start;
    logic      s_init;
    logic      in_acc;
    logic      has_byte;
    logic      emit_take;
    logic [5:0] s_pos;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;
    assign has_byte   = in_acc & ~i_carries_no_byte;
    assign s_pos      = r_count[5:0];
    assign emit_take  = (r_state == S_EMIT) & (~r_out_valid | i_out_ready);

    sha1h_engine u_eng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_start),
        .i_init  (s_init),
        .i_cmd   (s_cmd),
        .o_stat  (s_eng),
        .o_hash  (s_hash)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pend_pad  = r_pend_pad;
        n_second    = r_second;
        n_final     = r_final;
        n_out_valid = r_out_valid & ~i_out_ready;
        s_cmd       = '0;
        s_start     = 1'b0;
        s_init      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (has_byte) begin
                    s_cmd.byte_wr = 1'b1;
                    s_cmd.pos     = s_pos;
                    s_cmd.data    = i_data_byte;
                    n_count       = r_count + 61'd1;
                    if (s_pos == 6'd63) begin
                        s_start    = 1'b1;
                        n_final    = 1'b0;
                        n_pend_pad = i_is_last;
                        n_state    = S_COMP;
                    end else if (i_is_last) begin
                        n_state = S_PAD;
                    end
                end else if (in_acc && i_is_last) begin
                    n_state = S_PAD;
                end
            end
            S_COMP: begin
                if (s_eng.done) begin
                    if (r_final) begin
                        n_state = S_EMIT;
                    end else if (r_second || r_pend_pad) begin
                        n_pend_pad = 1'b0;
                        n_state    = S_PAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_PAD: begin
                s_cmd.pad_wr   = 1'b1;
                s_cmd.pos      = s_pos;
                s_cmd.zero_all = r_second;
                s_cmd.bit_len  = {r_count, 3'b000};
                // no room for the length when the mark lands in the last 8 bytes
                s_cmd.put_len  = r_second | (s_pos[5:3] != 3'b111);
                s_start        = 1'b1;
                n_final        = s_cmd.put_len;
                n_second       = ~s_cmd.put_len;
                n_state        = S_COMP;
            end
            S_EMIT: begin
                if (emit_take) begin
                    s_init      = 1'b1;
                    n_count     = '0;
                    n_final     = 1'b0;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend_pad  <= 1'b0;
            r_second    <= 1'b0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend_pad  <= n_pend_pad;
            r_second    <= n_second;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_take) begin
            r_dig_high   <= {s_hash[0], s_hash[1]};
            r_dig_middle <= {s_hash[2], s_hash[3]};
            r_dig_low    <= s_hash[4];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_digest_high   = r_dig_high;
    assign o_digest_middle = r_dig_middle;
    assign o_digest_low    = r_dig_low;

    // no request taken while the round engine works on a block
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !s_eng.busy)
        else $error("request accepted while round engine busy");

    // a new digest only comes out of the emit state
    a_digest_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) ##1 o_out_valid |-> $past(r_state == S_EMIT))
        else $error("digest presented without a finished message");

    // the byte count restarts after every digest
    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_take |=> (r_count == '0 && r_state == S_IDLE))
        else $error("byte count not cleared after digest");

    // the padding pass always starts a compression from an idle engine
    a_pad_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD) |-> (!s_eng.busy && s_start))
        else $error("padding pass with busy engine");

endmodule

FILE: dv/tb_sha1_byte_stream_hash_unit.sv
// testbench for the sha-1 byte stream hash unit: directed and random messages checked against a local sha-1 model
`timescale 1ns / 100ps

module tb_sha1_byte_stream_hash_unit;
    import sha1h_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned HOLD_CYCLES   = 1500;
    localparam int unsigned SETTLE_CYCLES = 250;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] mid;
        logic [31:0] lo;
    } t_digest;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        is_last   = 1'b0;
    logic        no_byte   = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] dig_hi;
    logic [63:0] dig_mid;
    logic [31:0] dig_lo;

    // local sha-1 state
    t_word       hash_words [5];
    t_word       blk_words [16];
    logic [60:0] byte_cnt;
    t_digest     digests_due [$];

    int unsigned err_cnt          = 0;
    int unsigned items_sent       = 0;
    int unsigned bytes_sent       = 0;
    int unsigned digests_expected = 0;
    int unsigned digests_seen     = 0;
    int unsigned cycle_cnt        = 0;
    logic [60:0] longest_msg      = '0;
    int unsigned tx_idle_pct      = 0;
    int unsigned rx_stall_pct     = 0;
    bit          rx_hold_req      = 1'b0;

    sha1_byte_stream_hash_unit uut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_data_byte       (data_byte),
        .i_is_last         (is_last),
        .i_carries_no_byte (no_byte),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_digest_high     (dig_hi),
        .o_digest_middle   (dig_mid),
        .o_digest_low      (dig_lo)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_sha1_byte_stream_hash_unit: done, errors");
            $finish;
        end
    end

    function automatic t_word rotl(input t_word x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_hash();
        int i;
        for (i = 0; i < 5; i++)
            hash_words[i] = HASH_INIT[i];
        byte_cnt = '0;
    endfunction

    function automatic void compress_block();
        t_word w [80];
        t_word a, b, c, d, e, f, k, t;
        int i;
        for (i = 0; i < 16; i++)
            w[i] = blk_words[i];
        for (i = 16; i < ROUNDS; i++)
            w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = hash_words[0];
        b = hash_words[1];
        c = hash_words[2];
        d = hash_words[3];
        e = hash_words[4];
        for (i = 0; i < ROUNDS; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = K_ROUND0;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = K_ROUND1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_ROUND2;
            end else begin
                f = b ^ c ^ d;
                k = K_ROUND3;
            end
            t = rotl(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        hash_words[0] += a;
        hash_words[1] += b;
        hash_words[2] += c;
        hash_words[3] += d;
        hash_words[4] += e;
    endfunction

    // big-endian byte lanes; lane 0 starts a fresh word
    function automatic void put_byte(input int unsigned p, input logic [7:0] v);
        int unsigned wi;
        int unsigned sh;
        wi = p / 4;
        sh = (3 - p % 4) * 8;
        if (p % 4 == 0)
            blk_words[wi] = {v, 24'h000000};
        else
            blk_words[wi] = blk_words[wi] | (t_word'(v) << sh);
    endfunction

    function automatic void absorb_request(input logic [7:0] b, input logic last,
                                           input logic nob);
        int unsigned p;
        logic [63:0] bit_len;
        t_digest d;
        if (!nob) begin
            p = 32'(byte_cnt[5:0]);
            put_byte(p, b);
            byte_cnt = byte_cnt + 61'd1;
            bytes_sent++;
            if (p == 63)
                compress_block();
        end
        if (last) begin
            bit_len = {byte_cnt, 3'b000};
            p = 32'(byte_cnt[5:0]);
            put_byte(p, PAD_MARK);
            p++;
            // a length field that no longer fits costs an extra block
            while (p != 56) begin
                if (p == 64) begin
                    compress_block();
                    p = 0;
                end else begin
                    put_byte(p, 8'h00);
                    p++;
                end
            end
            blk_words[14] = bit_len[63:32];
            blk_words[15] = bit_len[31:0];
            compress_block();
            d.hi  = {hash_words[0], hash_words[1]};
            d.mid = {hash_words[2], hash_words[3]};
            d.lo  = hash_words[4];
            digests_due = {digests_due, d};
            digests_expected++;
            if (byte_cnt > longest_msg)
                longest_msg = byte_cnt;
            restart_hash();
        end
    endfunction

    // called right after a rising edge; returns at the edge that takes the request
    task automatic send_item(input logic [7:0] b, input logic last, input logic nob);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        is_last   <= last;
        no_byte   <= nob;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        absorb_request(b, last, nob);
        items_sent++;
    endtask

    task automatic send_message(input int unsigned len);
        logic split_end;
        int unsigned i;
        split_end = (len == 0) || ($urandom_range(3) == 0);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(24) == 0)
                send_item(8'($urandom), 1'b0, 1'b1);
            send_item(8'($urandom), !split_end && (i == len - 1), 1'b0);
        end
        if (split_end)
            send_item(8'($urandom), 1'b1, 1'b1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (digests_due.size() != 0);
    endtask

    function automatic int unsigned pick_length();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return $urandom_range(12);
        if (sel == 9)
            return $urandom_range(140);
        // lengths around the one-or-two padding block split
        unique case ($urandom_range(7))
            0: return 55;
            1: return 56;
            2: return 57;
            3: return 63;
            4: return 64;
            5: return 65;
            6: return 119;
            default: return 120;
        endcase
    endfunction

    task automatic test_directed_corners();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h61, 1'b0, 1'b0);
        send_item(8'h62, 1'b0, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        // bare end mark after bytes
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'ha5, 1'b0, 1'b0);
        send_item(8'h3c, 1'b1, 1'b1);
        send_item(8'h81, 1'b0, 1'b1);
        send_item(8'h7e, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_padding_boundaries();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64);
        send_message(0);
        wait_drained();
    endtask

    // output held off long enough that a second digest backs up into the input
    task automatic test_output_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_req  = 1'b1;
        send_message(3);
        send_message(0);
        send_message(9);
        send_message(2);
        send_message(1);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int unsigned n_items, input int unsigned tx_pct,
                                       input int unsigned rx_pct);
        int unsigned first_item;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        first_item   = items_sent;
        while (items_sent - first_item < n_items) begin
            send_message(pick_length());
            if ($urandom_range(9) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rx_hold_req) begin
                hold_left   = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        t_digest want;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            if (digests_due.size() == 0) begin
                $error("digest with no message pending: %h %h %h", dig_hi, dig_mid, dig_lo);
                err_cnt++;
            end else begin
                want = digests_due.pop_front();
                digests_seen++;
                if (dig_hi !== want.hi) begin
                    $error("digest_high: expected %h, got %h", want.hi, dig_hi);
                    err_cnt++;
                end
                if (dig_mid !== want.mid) begin
                    $error("digest_middle: expected %h, got %h", want.mid, dig_mid);
                    err_cnt++;
                end
                if (dig_lo !== want.lo) begin
                    $error("digest_low: expected %h, got %h", want.lo, dig_lo);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        restart_hash();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_corners();
        test_padding_boundaries();
        test_output_backpressure();
        test_random_traffic(140, 0, 0);
        test_random_traffic(140, 49, 0);
        test_random_traffic(140, 0, 49);
        test_random_traffic(140, 22, 22);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (digests_due.size() != 0) begin
            $error("%0d digests never arrived", digests_due.size());
            err_cnt++;
        end
        $display("covered %0d requests, %0d message bytes, %0d digests checked, longest %0d bytes",
                 items_sent, bytes_sent, digests_seen, longest_msg);
        $display("idle mixes: none, sender, receiver, both; one long output hold-off");
        if (err_cnt == 0)
            $display("tb_sha1_byte_stream_hash_unit: done, clean");
        else
            $display("tb_sha1_byte_stream_hash_unit: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/sha1h_pkg.sv
rtl/sha1h_engine.sv
rtl/sha1_byte_stream_hash_unit.sv
dv/tb_sha1_byte_stream_hash_unit.sv
